### rtl/rrts_pkg.sv
// Shared types and constants of the round-robin task scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
package rrts_pkg;

  localparam int MAX_TASKS_DEF   = 16;
  localparam int FRAME_BYTES_DEF = 68;

  localparam int SLOT_W = 4;   // task_slot and chosen_slot field width
  localparam int SP_W   = 32;  // stack pointer and address width

  typedef enum logic [1:0] {
    REQ_SWITCH = 2'd0,
    REQ_CREATE = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_REJECT    = 2'd2
  } status_e;

  // Read address source of the successor memory.
  typedef enum logic [1:0] {
    SA_NODE = 2'd0,
    SA_CUR  = 2'd1,
    SA_SLOT = 2'd2
  } succ_addr_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SW_NEXT,
    S_SW_LOAD,
    S_WALK,
    S_WALK_WAIT,
    S_RM_UNLINK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic       capture;
    logic       node_clr;
    logic       node_adv;
    logic       succ_re;
    succ_addr_e succ_addr;
    logic       link_tail;
    logic       unlink;
    logic       sp_save;
    logic       sp_init;
    logic       cur_adv;
    logic       sp_re;
    logic       res_load;
    status_e    res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       create_bad;
    logic       remove_bad;
    logic       node_vld;
    logic       succ_hit;
    logic       res_free;
  } dp_sts_t;

endpackage

### rtl/rrts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module rrts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rrts_dp.sv
// Datapath of the task scheduler: request registers, run list, stack pointers
// and the result register. Depends on rrts_pkg and rrts_ram.
module rrts_dp import rrts_pkg::*; #(
  parameter int MAX_TASKS   = MAX_TASKS_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  input  logic [1:0]        req_type_i,
  input  logic [SLOT_W-1:0] task_slot_i,
  input  logic [SP_W-1:0]   stack_base_i,
  input  logic [SP_W-1:0]   stack_bytes_i,
  input  logic [SP_W-1:0]   outgoing_sp_i,
  input  logic              res_ready_i,
  output logic              res_valid_o,
  output logic [SLOT_W-1:0] chosen_slot_o,
  output logic [SP_W-1:0]   chosen_sp_o,
  output logic [1:0]        status_o
);

  localparam int IdxW = $clog2(MAX_TASKS);
  localparam logic [8:0] MaxTasksL = 9'(MAX_TASKS);
  localparam logic [MAX_TASKS-1:0] ListedRst = MAX_TASKS'(1);
  localparam logic [SP_W-1:0] AlignMask = ~SP_W'(7);

  // Captured request.
  logic [1:0]        req_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SP_W-1:0]   sum_q;
  logic [SP_W-1:0]   sp_q;
  logic [IdxW-1:0]   slot_idx;

  // Run list state.
  logic [MAX_TASKS-1:0] listed_q, listed_d;
  logic [MAX_TASKS-1:0] succ_vld_q, succ_vld_d;
  logic [IdxW-1:0]      cur_q, cur_d;
  logic [IdxW-1:0]      node_q, node_d;

  // Memory ports.
  logic            succ_we;
  logic [IdxW-1:0] succ_wdata, succ_raddr, succ_rdata;
  logic            sp_we;
  logic [IdxW-1:0] sp_waddr;
  logic [SP_W-1:0] sp_wdata, sp_init_val, sp_rdata;

  // Result register.
  logic              res_vld_q, res_vld_d;
  logic [SLOT_W-1:0] res_slot_q;
  logic [SP_W-1:0]   res_sp_q;
  logic [1:0]        res_st_q;

  logic slot_ok, slot_zero;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      slot_q <= task_slot_i;
      sum_q  <= stack_base_i + stack_bytes_i;
      sp_q   <= outgoing_sp_i;
    end
  end

  assign slot_idx  = IdxW'(slot_q);
  assign slot_ok   = {5'd0, slot_q} < MaxTasksL;
  assign slot_zero = (slot_q == '0);

  assign sp_init_val = (sum_q - SP_W'(FRAME_BYTES)) & AlignMask;

  always_comb begin
    unique case (cmd_i.succ_addr)
      SA_NODE: succ_raddr = node_q;
      SA_CUR:  succ_raddr = cur_q;
      SA_SLOT: succ_raddr = slot_idx;
      default: succ_raddr = node_q;
    endcase
  end

  assign succ_we    = cmd_i.link_tail | cmd_i.unlink;
  assign succ_wdata = cmd_i.link_tail ? slot_idx : succ_rdata;

  assign sp_we    = cmd_i.sp_save | cmd_i.sp_init;
  assign sp_waddr = cmd_i.sp_save ? cur_q : slot_idx;
  assign sp_wdata = cmd_i.sp_save ? sp_q : sp_init_val;

  rrts_ram #(
    .WIDTH(IdxW),
    .DEPTH(MAX_TASKS)
  ) u_succ_ram (
    .clk_i  (clk_i),
    .we_i   (succ_we),
    .waddr_i(node_q),
    .wdata_i(succ_wdata),
    .re_i   (cmd_i.succ_re),
    .raddr_i(succ_raddr),
    .rdata_o(succ_rdata)
  );

  rrts_ram #(
    .WIDTH(SP_W),
    .DEPTH(MAX_TASKS)
  ) u_sp_ram (
    .clk_i  (clk_i),
    .we_i   (sp_we),
    .waddr_i(sp_waddr),
    .wdata_i(sp_wdata),
    .re_i   (cmd_i.sp_re),
    .raddr_i(cur_q),
    .rdata_o(sp_rdata)
  );

  // A successor entry without its valid bit reads as "none".
  always_comb begin
    listed_d   = listed_q;
    succ_vld_d = succ_vld_q;
    cur_d      = cur_q;
    node_d     = node_q;
    if (cmd_i.link_tail) begin
      succ_vld_d[node_q]   = 1'b1;
      succ_vld_d[slot_idx] = 1'b0;
      listed_d[slot_idx]   = 1'b1;
    end
    if (cmd_i.unlink) begin
      succ_vld_d[node_q]   = succ_vld_q[slot_idx];
      succ_vld_d[slot_idx] = 1'b0;
      listed_d[slot_idx]   = 1'b0;
    end
    if (cmd_i.cur_adv) begin
      cur_d = succ_vld_q[cur_q] ? succ_rdata : '0;
    end
    if (cmd_i.node_clr) begin
      node_d = '0;
    end else if (cmd_i.node_adv) begin
      node_d = succ_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listed_q   <= ListedRst;
      succ_vld_q <= '0;
      cur_q      <= '0;
      node_q     <= '0;
    end else begin
      listed_q   <= listed_d;
      succ_vld_q <= succ_vld_d;
      cur_q      <= cur_d;
      node_q     <= node_d;
    end
  end

  always_comb begin
    res_vld_d = res_vld_q;
    if (cmd_i.res_load) begin
      res_vld_d = 1'b1;
    end else if (res_ready_i) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_slot_q <= SLOT_W'(cur_q);
      res_sp_q   <= (req_q == REQ_SWITCH) ? sp_rdata : '0;
      res_st_q   <= cmd_i.res_status;
    end
  end

  assign sts_o.req        = req_q;
  assign sts_o.create_bad = slot_zero | ~slot_ok | listed_q[slot_idx];
  assign sts_o.remove_bad = slot_zero | ~slot_ok | ~listed_q[slot_idx];
  assign sts_o.node_vld   = succ_vld_q[node_q];
  assign sts_o.succ_hit   = (succ_rdata == slot_idx);
  assign sts_o.res_free   = ~res_vld_q | res_ready_i;

  assign res_valid_o   = res_vld_q;
  assign chosen_slot_o = res_slot_q;
  assign chosen_sp_o   = res_sp_q;
  assign status_o      = res_st_q;

`ifndef SYNTHESIS
  a_main_listed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    listed_q[0])
    else $error("main task dropped from the run list");

  a_succ_of_listed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (succ_vld_q & ~listed_q) == '0)
    else $error("unlisted slot still has a successor");

  a_link_no_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.link_tail |-> node_q != slot_idx)
    else $error("new slot linked to itself");
`endif

endmodule

### rtl/rrts_ctrl.sv
// Controller state machine of the task scheduler: sequences list walks,
// memory accesses and the result load. Depends on rrts_pkg.
module rrts_ctrl import rrts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e  state_q, state_d;
  status_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    st_d             = st_q;
    cmd_o            = '0;
    cmd_o.res_status = st_q;
    in_ready_o       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.req)
          REQ_SWITCH: begin
            // Save the outgoing pointer and fetch the current successor.
            cmd_o.sp_save   = 1'b1;
            cmd_o.succ_re   = 1'b1;
            cmd_o.succ_addr = SA_CUR;
            st_d            = ST_OK;
            state_d         = S_SW_NEXT;
          end
          REQ_CREATE: begin
            if (sts_i.create_bad) begin
              st_d    = ST_REJECT;
              state_d = S_DONE;
            end else begin
              cmd_o.sp_init  = 1'b1;
              cmd_o.node_clr = 1'b1;
              state_d        = S_WALK;
            end
          end
          REQ_REMOVE: begin
            if (sts_i.remove_bad) begin
              st_d    = ST_NOT_FOUND;
              state_d = S_DONE;
            end else begin
              cmd_o.node_clr = 1'b1;
              state_d        = S_WALK;
            end
          end
          default: begin
            st_d    = ST_REJECT;
            state_d = S_DONE;
          end
        endcase
      end
      S_SW_NEXT: begin
        cmd_o.cur_adv = 1'b1;
        state_d       = S_SW_LOAD;
      end
      S_SW_LOAD: begin
        cmd_o.sp_re = 1'b1;
        state_d     = S_DONE;
      end
      S_WALK: begin
        if (!sts_i.node_vld) begin
          // End of the list: the tail for a create, a miss for a remove.
          if (sts_i.req == REQ_CREATE) begin
            cmd_o.link_tail = 1'b1;
            st_d            = ST_OK;
          end else begin
            st_d = ST_NOT_FOUND;
          end
          state_d = S_DONE;
        end else begin
          cmd_o.succ_re   = 1'b1;
          cmd_o.succ_addr = SA_NODE;
          state_d         = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: begin
        if (sts_i.req == REQ_REMOVE && sts_i.succ_hit) begin
          // The walk node is the predecessor; fetch the removed slot's successor.
          cmd_o.succ_re   = 1'b1;
          cmd_o.succ_addr = SA_SLOT;
          state_d         = S_RM_UNLINK;
        end else begin
          cmd_o.node_adv = 1'b1;
          state_d        = S_WALK;
        end
      end
      S_RM_UNLINK: begin
        cmd_o.unlink = 1'b1;
        st_d         = ST_OK;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (sts_i.res_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> sts_i.res_free)
    else $error("result register overwritten before it was taken");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.link_tail, cmd_o.unlink, cmd_o.sp_save, cmd_o.sp_init}))
    else $error("more than one memory update in a cycle");

  a_load_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |=> state_q == S_IDLE)
    else $error("controller did not return to idle after a result");
`endif

endmodule

### rtl/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler.
// Depends on rrts_pkg, rrts_ctrl, rrts_dp and rrts_ram.
//
// The scheduler keeps a run list of task slots, with slot 0 (the main task)
// always at its head, and a saved stack pointer per slot. Each request on the
// slave stream yields exactly one response on the master stream. A switch
// request stores outgoing_sp for the current slot, moves to its successor or
// wraps to the head, and returns the new slot with its saved stack pointer.
// A create request appends a slot at the tail with an initial stack pointer
// of (stack_base + stack_bytes - FRAME_BYTES) rounded down to a multiple of
// 8, modulo 2^32; a create of slot 0, of a listed slot or of a slot not below
// MAX_TASKS is rejected. A remove request unlinks a listed slot other than
// slot 0, or reports not found. Removing the current slot leaves it current,
// and the next switch then goes to the head. Request type 3 is rejected.
// Requests are handled one at a time. A switch passes through the dispatch,
// next-successor and load states before its response is loaded. A create
// walks the list to its tail and a remove walks it to the predecessor of the
// slot, each list hop going through the single read port of the successor
// memory in the walk and walk-wait states. A response is loaded only once
// the result register is free. The next request is accepted in the cycle
// after the response is loaded, even if the response has not yet been taken
// downstream. A saved stack pointer read before its slot was ever created or
// switched away from is undefined.
module round_robin_task_scheduler import rrts_pkg::*; #(
  parameter int MAX_TASKS   = MAX_TASKS_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Request stream.
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [3:0] task_slot, [35:4] stack_base, [67:36] stack_bytes,
  // [99:68] outgoing_sp, [103:100] zero
  input  logic [103:0] s_axis_tdata_i,
  // [1:0] req_type
  input  logic [1:0]   s_axis_tuser_i,
  // Response stream.
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [3:0] chosen_slot, [35:4] chosen_sp, [39:36] zero
  output logic [39:0]  m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]   m_axis_tuser_o
);

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [SLOT_W-1:0] chosen_slot;
  logic [SP_W-1:0]   chosen_sp;

  // The controller only sequences; all state of the run list and the
  // result register live in the datapath.
  rrts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rrts_dp #(
    .MAX_TASKS  (MAX_TASKS),
    .FRAME_BYTES(FRAME_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (s_axis_tuser_i),
    .task_slot_i  (s_axis_tdata_i[3:0]),
    .stack_base_i (s_axis_tdata_i[35:4]),
    .stack_bytes_i(s_axis_tdata_i[67:36]),
    .outgoing_sp_i(s_axis_tdata_i[99:68]),
    .res_ready_i  (m_axis_tready_i),
    .res_valid_o  (m_axis_tvalid_o),
    .chosen_slot_o(chosen_slot),
    .chosen_sp_o  (chosen_sp),
    .status_o     (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {4'd0, chosen_sp, chosen_slot};

endmodule

### tb/round_robin_task_scheduler_test.sv
// Self-checking testbench for the round-robin task scheduler.
// Needs rrts_pkg and round_robin_task_scheduler; a scoreboard class keeps its own
// copy of the run list and checks every response against it.
module round_robin_task_scheduler_test import rrts_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned RANDOM_REQUESTS = 750;
  localparam logic [4:0] SLOT_NONE = 5'(MAX_TASKS_DEF);
  localparam logic [1:0] REQ_ILLEGAL = 2'd3;  // request type with no meaning

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic [SP_W-1:0]   sp;
    status_e           status;
  } sched_resp_t;

  // Shadow run list: predicts the response of each accepted request and
  // compares responses in order.
  class run_list_scoreboard;
    logic [4:0]      next_slot [MAX_TASKS_DEF];
    bit              in_list [MAX_TASKS_DEF];
    logic [SP_W-1:0] stack_ptr [MAX_TASKS_DEF];
    logic [3:0]      cur;
    sched_resp_t     expected_responses [$];
    int unsigned     errors;

    function new();
      for (int i = 0; i < MAX_TASKS_DEF; i++) begin
        next_slot[i] = SLOT_NONE;
        in_list[i]   = 1'b0;
        stack_ptr[i] = '0;
      end
      in_list[0] = 1'b1;
      cur        = '0;
      errors     = 0;
    endfunction

    function int unsigned pending();
      return expected_responses.size();
    endfunction

    function void note_request(logic [1:0] kind, logic [3:0] slot, logic [31:0] base,
                               logic [31:0] bytes, logic [31:0] sp);
      sched_resp_t r;
      logic [4:0]  node;
      r.sp     = '0;
      r.status = ST_OK;
      case (kind)
        REQ_SWITCH: begin
          stack_ptr[cur] = sp;
          node = next_slot[cur];
          // A slot without successor (tail, or a removed current slot) wraps to the head.
          cur  = (node == SLOT_NONE) ? 4'd0 : node[3:0];
          r.sp = stack_ptr[cur];
        end
        REQ_CREATE: begin
          if (slot == 4'd0 || in_list[slot]) begin
            r.status = ST_REJECT;
          end else begin
            stack_ptr[slot] = (base + bytes - 32'(FRAME_BYTES_DEF)) & ~32'd7;
            node = 5'd0;
            while (next_slot[node[3:0]] != SLOT_NONE) node = next_slot[node[3:0]];
            next_slot[node[3:0]] = {1'b0, slot};
            next_slot[slot]      = SLOT_NONE;
            in_list[slot]        = 1'b1;
          end
        end
        REQ_REMOVE: begin
          if (slot == 4'd0 || !in_list[slot]) begin
            r.status = ST_NOT_FOUND;
          end else begin
            node = 5'd0;
            while (node != SLOT_NONE && next_slot[node[3:0]] != {1'b0, slot})
              node = next_slot[node[3:0]];
            if (node == SLOT_NONE) begin
              r.status = ST_NOT_FOUND;
            end else begin
              next_slot[node[3:0]] = next_slot[slot];
              next_slot[slot]      = SLOT_NONE;
              in_list[slot]        = 1'b0;
            end
          end
        end
        default: r.status = ST_REJECT;
      endcase
      r.slot = cur;
      expected_responses.push_back(r);
    endfunction

    function void check_response(logic [3:0] slot, logic [31:0] sp, logic [1:0] status);
      sched_resp_t exp;
      if (expected_responses.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected response: slot %0d sp %h status %0d", slot, sp, status);
        return;
      end
      exp = expected_responses.pop_front();
      if (slot !== exp.slot || sp !== exp.sp || status !== exp.status) begin
        errors++;
        if (errors <= 10)
          $display("response mismatch: slot %0d/%0d sp %h/%h status %0d/%0d (exp/got)",
                   exp.slot, slot, exp.sp, sp, exp.status, status);
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready_o;
  logic [103:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = REQ_SWITCH;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  int unsigned        cycles = 0;
  int unsigned        rx_stall = 0;
  bit                 tx_steady = 1'b0;
  run_list_scoreboard sb = new();

  round_robin_task_scheduler u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return $urandom_range(1, 2);
    if (p < 90) return $urandom_range(3, 6);
    return $urandom_range(12, 30);
  endfunction

  // Word values that favor the extremes of the 32-bit range.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  // Response side: checks every accepted response and stalls at random,
  // except during one stretch out of three.
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready)
      sb.check_response(m_axis_tdata_o[3:0], m_axis_tdata_o[35:4], m_axis_tuser_o);
    if (rx_stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ((cycles / 2000) % 3 != 0 && $urandom_range(0, 3) == 0)
        rx_stall <= pick_gap();
    end
  end

  // Presents one request after an optional gap and returns at the edge where
  // it is accepted; valid is left high so back-to-back requests stay clean.
  task automatic send_request(logic [1:0] kind, logic [3:0] slot, logic [31:0] base,
                              logic [31:0] bytes, logic [31:0] sp);
    int unsigned gap;
    gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, sp, bytes, base, slot};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_request(kind, slot, base, bytes, sp);
  endtask

  // Holds the request side idle until every response has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [1:0]  kind;
    int unsigned p;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a lone main task, rejected and missing slots, the
    // illegal request type, address wrap in both directions and removal of
    // a middle entry.
    send_request(REQ_SWITCH, 4'd0, '0, '0, 32'h0000_0000);
    send_request(REQ_SWITCH, 4'd0, '0, '0, 32'hFFFF_FFFF);
    send_request(REQ_CREATE, 4'd0, 32'h1000, 32'h100, '0);
    send_request(REQ_REMOVE, 4'd0, '0, '0, '0);
    send_request(REQ_REMOVE, 4'd7, '0, '0, '0);
    send_request(REQ_ILLEGAL, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_CREATE, 4'd1, 32'h0000_0000, 32'h0000_0000, '0);
    send_request(REQ_CREATE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_request(REQ_CREATE, 4'd1, 32'h2000_0000, 32'h400, '0);
    send_request(REQ_CREATE, 4'd8, 32'h2000_0000, 32'h400, '0);
    send_request(REQ_SWITCH, 4'd0, '0, '0, 32'h1234_5678);
    send_request(REQ_SWITCH, 4'd0, '0, '0, 32'h8000_0001);
    send_request(REQ_SWITCH, 4'd0, '0, '0, 32'h7FFF_FFFE);
    send_request(REQ_REMOVE, 4'd15, '0, '0, '0);
    send_request(REQ_SWITCH, 4'd0, '0, '0, 32'hDEAD_BEE8);
    send_request(REQ_REMOVE, 4'd15, '0, '0, '0);
    send_request(REQ_CREATE, 4'd15, 32'h0000_0005, 32'h0000_0045, '0);
    send_request(REQ_SWITCH, 4'd0, '0, '0, 32'h0000_0010);
    send_request(REQ_REMOVE, 4'd8, '0, '0, '0);
    send_request(REQ_SWITCH, 4'd0, '0, '0, 32'h0000_0020);
    send_request(REQ_SWITCH, 4'd0, '0, '0, 32'h0000_0030);
    send_request(REQ_REMOVE, 4'd1, '0, '0, '0);
    send_request(REQ_REMOVE, 4'd15, '0, '0, '0);
    send_request(REQ_SWITCH, 4'd0, '0, '0, 32'h5555_AAAA);
    drain();

    // Random part. The mix keeps about two thirds of the slots listed on average,
    // so list walks of every length occur. Unused fields carry noise.
    for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
      tx_steady = ((i / 120) % 4 == 3);
      p = $urandom_range(0, 99);
      if (p < 40) kind = REQ_SWITCH;
      else if (p < 75) kind = REQ_CREATE;
      else if (p < 95) kind = REQ_REMOVE;
      else kind = REQ_ILLEGAL;
      send_request(kind, 4'($urandom_range(0, 15)), pick_word(), pick_word(), pick_word());
      if (i == 300 || i == 600) drain();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
